// File: rtl/bsbez_pkg.sv
package bsbez_pkg;

   // coordinate width, two's complement fixed point
   localparam int COORD_BITS = 32;
   // floor(u/3) of an unsigned coordinate fits one bit less
   localparam int QUOT_BITS = COORD_BITS - 1;
   // room for six times a third plus carries
   localparam int SUM_BITS = COORD_BITS + 3;

   // reciprocal of three, ceil(2^(COORD_BITS+1)/3), exact for every unsigned coordinate
   localparam logic [63:0] RECIP_POW = 64'd1 << (COORD_BITS + 1);
   localparam logic [COORD_BITS-1:0] RECIP =
      COORD_BITS'((RECIP_POW + 64'd3 - (RECIP_POW % 64'd3)) / 64'd3);

   // offset binary bias 2^(COORD_BITS-1) split into 3*quot + rem
   localparam logic [63:0] HALF_POW = 64'd1 << (COORD_BITS - 1);
   localparam logic [COORD_BITS-1:0] BIAS_QUOT = COORD_BITS'(HALF_POW / 64'd3);
   localparam logic [1:0] BIAS_REM = 2'(HALF_POW % 64'd3);

   localparam logic [2:0] SEEN_FIRST = 3'd3;
   localparam logic [2:0] SEEN_MAX = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // a coordinate held as p = 3*q + r with 0 <= r < 3
   typedef struct packed {
      coord_type  q;
      logic [1:0] r;
   } third_type;

   // x, y, z at index 0, 1, 2
   typedef third_type [2:0] tpoint_type;

   typedef enum logic [1:0] {
      KIND_JUNCTION,
      KIND_NEAR,
      KIND_FAR,
      KIND_END
   } kind_type;

endpackage

// File: rtl/bsbez_if.sv
interface bsbez_req_if import bsbez_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type in_x;
   coord_type in_y;
   coord_type in_z;
   logic      new_curve;

   modport source (output valid, output in_x, output in_y, output in_z, output new_curve,
                   input ready);
   modport sink (input valid, input in_x, input in_y, input in_z, input new_curve,
                 output ready);
endinterface

interface bsbez_rsp_if import bsbez_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      run_last;

   modport source (output valid, output out_x, output out_y, output out_z, output run_last,
                   input ready);
   modport sink (input valid, input out_x, input out_y, input out_z, input run_last,
                 output ready);
endinterface

// File: rtl/bsbez_blend.sv
module bsbez_blend import bsbez_pkg::*; (
   input  kind_type        kind,
   input  third_type [3:0] pts,
   output coord_type       result
);

   third_type                   f, g, h;
   logic                        wide_g;
   logic                        by_six;
   logic signed [SUM_BITS-1:0]  g_q;
   logic signed [SUM_BITS-1:0]  q_sum;
   logic signed [SUM_BITS-1:0]  res;
   logic [3:0]                  r_sum;
   logic [3:0]                  v;
   logic [1:0]                  frac;

   always_comb begin
      f = '0;
      g = '0;
      h = '0;
      wide_g = 1'b0;
      by_six = 1'b0;
      unique case (kind)
         KIND_JUNCTION: begin
            f = pts[0];
            g = pts[1];
            h = pts[2];
            wide_g = 1'b1;
            by_six = 1'b1;
         end
         KIND_NEAR: begin
            f = pts[2];
            g = pts[1];
         end
         KIND_FAR: begin
            f = pts[1];
            g = pts[2];
         end
         KIND_END: begin
            f = pts[1];
            g = pts[2];
            h = pts[3];
            wide_g = 1'b1;
            by_six = 1'b1;
         end
      endcase

      // weighted sum of quotients and of remainders kept apart
      g_q = SUM_BITS'(g.q);
      q_sum = SUM_BITS'(f.q) + (wide_g ? (g_q <<< 2) : (g_q <<< 1)) + SUM_BITS'(h.q);
      r_sum = 4'(f.r) + (wide_g ? {g.r, 2'b00} : {1'b0, g.r, 1'b0}) + 4'(h.r);

      v = '0;
      if (by_six) begin
         // (3Q + R)/6 = Q>>1 + (3*odd(Q) + R)/6
         v = r_sum + (q_sum[0] ? 4'd3 : 4'd0);
         frac = (v >= 4'd12) ? 2'd2 : ((v >= 4'd6) ? 2'd1 : 2'd0);
         res = (q_sum >>> 1) + SUM_BITS'(frac);
      end else begin
         frac = (r_sum >= 4'd6) ? 2'd2 : ((r_sum >= 4'd3) ? 2'd1 : 2'd0);
         res = q_sum + SUM_BITS'(frac);
      end
      result = coord_type'(res[COORD_BITS-1:0]);
   end

endmodule

// File: rtl/bspline_to_bezier_points_core.sv
// channel   dir   handshake        payload
// req_bus   in    valid / ready    in_x, in_y, in_z, new_curve
// rsp_bus   out   valid / ready    out_x, out_y, out_z, run_last
//
// a point yields three bezier points in steady state, four for the point that opens a segment run,
// none for the first three points of a curve; the single output register emitting one
// bezier point per cycle while rsp_bus is ready sets the pace
// a point's first result passes the stage 1, stage 2, job and output registers in that order
// reset is synchronous: it clears the valids, the window and the count, no clearing pass
// a stalled rsp_bus holds the output register, then the job, then the two input stages
module bspline_to_bezier_points_core import bsbez_pkg::*; (
   input logic         clock,
   input logic         reset,
   bsbez_req_if.sink   req_bus,
   bsbez_rsp_if.source rsp_bus
);

   localparam int W = COORD_BITS;

   // stage 1: raw point, reciprocal multiply
   logic                           req_fire;
   logic                           s1_valid_ff, s1_valid_in;
   logic [2:0][W-1:0]              s1_pt_ff, s1_pt_in;
   logic                           s1_new_ff, s1_new_in;
   logic                           s1_move;
   logic [2:0][W-1:0]              s1_u;
   logic [2:0][2*W-1:0]            s1_prod;
   logic [2:0][QUOT_BITS-1:0]      s1_a;

   // stage 2: quotient and remainder by three
   logic                           s2_valid_ff, s2_valid_in;
   logic [2:0][W-1:0]              s2_u_ff, s2_u_in;
   logic [2:0][QUOT_BITS-1:0]      s2_a_ff, s2_a_in;
   logic                           s2_new_ff, s2_new_in;
   logic [2:0][W-1:0]              s2_three_a;
   logic [2:0][W-1:0]              s2_bfull;
   logic [2:0][1:0]                s2_b;
   coord_type                      q_base;
   tpoint_type                     s2_pt;
   logic [2:0]                     s2_count;
   logic                           s2_emits;
   logic                           s2_consume;
   logic                           s2_free;

   // curve state
   tpoint_type [2:0]               win_ff, win_in;
   logic [2:0]                     seen_ff, seen_in;

   // emission job
   logic                           job_valid_ff, job_valid_in;
   tpoint_type [3:0]               job_pts_ff, job_pts_in;
   kind_type                       job_kind_ff, job_kind_in;
   logic                           job_ready;
   logic                           emit_go;
   logic                           job_load;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2:0][W-1:0]              rsp_pt_ff, rsp_pt_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic [2:0][W-1:0]              blend_pt;

   // handshake and flow control
   always_comb begin
      req_fire = req_bus.valid && req_bus.ready;
      // new_curve clears the count before this point is counted
      s2_count = s2_new_ff ? 3'd0 : seen_ff;
      s2_emits = s2_count >= SEEN_FIRST;
      emit_go = job_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
      // the job frees up on the beat of its last bezier point
      job_ready = !job_valid_ff || (emit_go && job_kind_ff == KIND_END);
      // points that give no result pass the job stage by
      s2_consume = s2_valid_ff && (!s2_emits || job_ready);
      s2_free = !s2_valid_ff || s2_consume;
      s1_move = s1_valid_ff && s2_free;
      job_load = s2_consume && s2_emits;
   end

   assign req_bus.ready = !s1_valid_ff || s1_move;

   // stage 1: offset binary then multiply by the reciprocal of three
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s1_u[c] = {~s1_pt_ff[c][W-1], s1_pt_ff[c][W-2:0]};
         s1_prod[c] = (2*W)'(s1_u[c]) * (2*W)'(RECIP);
         s1_a[c] = s1_prod[c][2*W-1:W+1];
      end
   end

   // stage 2: residue, then undo the bias to get floor(p/3) and p mod 3
   always_comb begin
      q_base = '0;
      for (int c = 0; c < 3; c++) begin
         s2_three_a[c] = {s2_a_ff[c], 1'b0} + W'(s2_a_ff[c]);
         s2_bfull[c] = s2_u_ff[c] - s2_three_a[c];
         s2_b[c] = s2_bfull[c][1:0];
         q_base = coord_type'(W'(s2_a_ff[c]) - BIAS_QUOT);
         if (s2_b[c] >= BIAS_REM) begin
            s2_pt[c].q = q_base;
            s2_pt[c].r = s2_b[c] - BIAS_REM;
         end else begin
            // borrow one third from the quotient
            s2_pt[c].q = q_base - coord_type'(1);
            s2_pt[c].r = s2_b[c] + 2'd3 - BIAS_REM;
         end
      end
   end

   // one bezier coordinate per lane from the job's four points
   for (genvar c = 0; c < 3; c++) begin : g_coord
      third_type [3:0] src;
      coord_type       res;

      assign src = {job_pts_ff[3][c], job_pts_ff[2][c], job_pts_ff[1][c], job_pts_ff[0][c]};

      bsbez_blend u_blend (
         .kind   (job_kind_ff),
         .pts    (src),
         .result (res)
      );

      assign blend_pt[c] = res;
   end

   // next values
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pt_in = s1_pt_ff;
      s1_new_in = s1_new_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_pt_in = {req_bus.in_z, req_bus.in_y, req_bus.in_x};
         s1_new_in = req_bus.new_curve;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_u_in = s2_u_ff;
      s2_a_in = s2_a_ff;
      s2_new_in = s2_new_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_u_in = s1_u;
         s2_a_in = s1_a;
         s2_new_in = s1_new_ff;
      end else if (s2_consume) begin
         s2_valid_in = 1'b0;
      end

      // window shift and saturating count on every consumed point
      win_in = win_ff;
      seen_in = seen_ff;
      if (s2_consume) begin
         win_in = {s2_pt, win_ff[2], win_ff[1]};
         seen_in = (s2_count == SEEN_MAX) ? SEEN_MAX : s2_count + 3'd1;
      end

      job_valid_in = job_valid_ff;
      job_pts_in = job_pts_ff;
      job_kind_in = job_kind_ff;
      if (emit_go) begin
         unique case (job_kind_ff)
            KIND_JUNCTION: job_kind_in = KIND_NEAR;
            KIND_NEAR:     job_kind_in = KIND_FAR;
            KIND_FAR:      job_kind_in = KIND_END;
            KIND_END: begin
               job_kind_in = KIND_JUNCTION;
               job_valid_in = 1'b0;
            end
         endcase
      end
      // a fresh job takes over in the cycle the previous one ends
      if (job_load) begin
         job_valid_in = 1'b1;
         job_pts_in = {s2_pt, win_ff[2], win_ff[1], win_ff[0]};
         job_kind_in = (s2_count == SEEN_FIRST) ? KIND_JUNCTION : KIND_NEAR;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_pt_in = rsp_pt_ff;
      rsp_last_in = rsp_last_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_pt_in = blend_pt;
         rsp_last_in = (job_kind_ff == KIND_END);
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         job_valid_ff <= 1'b0;
         job_kind_ff <= KIND_JUNCTION;
         rsp_valid_ff <= 1'b0;
         win_ff <= '0;
         seen_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         job_valid_ff <= job_valid_in;
         job_kind_ff <= job_kind_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff <= win_in;
         seen_ff <= seen_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_pt_ff <= s1_pt_in;
      s1_new_ff <= s1_new_in;
      s2_u_ff <= s2_u_in;
      s2_a_ff <= s2_a_in;
      s2_new_ff <= s2_new_in;
      job_pts_ff <= job_pts_in;
      rsp_pt_ff <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_x = rsp_pt_ff[0];
   assign rsp_bus.out_y = rsp_pt_ff[1];
   assign rsp_bus.out_z = rsp_pt_ff[2];
   assign rsp_bus.run_last = rsp_last_ff;

`ifndef ASSERT_OFF
   // reciprocal multiply leaves a residue below three
   a_residue: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_bfull[0] < W'(3)) && (s2_bfull[1] < W'(3)) && (s2_bfull[2] < W'(3)))
      else $error("residue by three out of range");

   // after the closing beat a job is either gone or a fresh one from its head
   a_job_restart: assert property (@(posedge clock) disable iff (reset)
      (emit_go && job_kind_ff == KIND_END) |=>
         (!job_valid_ff || job_kind_ff == KIND_JUNCTION || job_kind_ff == KIND_NEAR))
      else $error("job resumed mid sequence");

   // a saturated count stays put unless a new curve starts
   a_seen_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_consume && !s2_new_ff && seen_ff == SEEN_MAX) |=> (seen_ff == SEEN_MAX))
      else $error("saturated point count moved");
`endif

endmodule

// File: test/tb_bspline_to_bezier_points_core.sv
module tb_bspline_to_bezier_points_core import bsbez_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // run length guard, far above the slowest correct run
   localparam int CYCLE_LIMIT = 200000;
   // margin after the last expected point, for stray beats to show
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES = 250;
   localparam int PHASE_POINTS = 40;

   localparam coord_type C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // one bezier control point as it leaves the block
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
   } bez_point_type;

   // predicts the bezier points of each accepted de boor point and checks them in order
   class bezier_board;
      longint        window[3][3];
      logic [2:0]    seen = '0;
      bez_point_type due_points[$];
      int            errors;
      int            checked;

      static function longint floor_div(longint s, longint d);
         longint q;
         q = s / d;
         if ((s % d) != 0 && s < 0)
            q = q - 1;
         return q;
      endfunction

      // append one expected point at the tail of the queue
      function void add_due(bez_point_type p);
         due_points = {due_points, p};
      endfunction

      task note_point(coord_type x, coord_type y, coord_type z, logic new_curve);
         longint    d3[3];
         coord_type jn[3], na[3], fa[3], en[3];
         int        c;
         d3[0] = x;
         d3[1] = y;
         d3[2] = z;
         if (new_curve)
            seen = '0;
         if (seen >= SEEN_FIRST) begin
            for (c = 0; c < 3; c++) begin
               jn[c] = coord_type'(floor_div(window[0][c] + 4 * window[1][c] + window[2][c], 6));
               na[c] = coord_type'(floor_div(2 * window[1][c] + window[2][c], 3));
               fa[c] = coord_type'(floor_div(window[1][c] + 2 * window[2][c], 3));
               en[c] = coord_type'(floor_div(window[1][c] + 4 * window[2][c] + d3[c], 6));
            end
            // the junction only opens a segment run
            if (seen == SEEN_FIRST)
               add_due('{jn[0], jn[1], jn[2], 1'b0});
            add_due('{na[0], na[1], na[2], 1'b0});
            add_due('{fa[0], fa[1], fa[2], 1'b0});
            add_due('{en[0], en[1], en[2], 1'b1});
         end
         for (c = 0; c < 3; c++) begin
            window[0][c] = window[1][c];
            window[1][c] = window[2][c];
            window[2][c] = d3[c];
         end
         if (seen < SEEN_MAX)
            seen = seen + 3'd1;
      endtask

      task report(string what);
         errors++;
         $display("mismatch on bezier point %0d: %s", checked, what);
      endtask

      task check_point(coord_type x, coord_type y, coord_type z, logic last);
         bez_point_type e;
         if (due_points.size() == 0) begin
            report("beat arrived with no point pending");
         end else begin
            e = due_points.pop_front();
            if (x !== e.x)
               report($sformatf("x is %0d, want %0d", x, e.x));
            if (y !== e.y)
               report($sformatf("y is %0d, want %0d", y, e.y));
            if (z !== e.z)
               report($sformatf("z is %0d, want %0d", z, e.z));
            if (last !== e.last)
               report($sformatf("run_last is %b, want %b", last, e.last));
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic stall = 1'b0;

   int send_idle_pct = 15;
   int recv_idle_pct = 72;
   int points_sent = 0;
   int curves_started = 0;
   int cycle_count = 0;

   bezier_board board;

   bsbez_req_if req_bus ();
   bsbez_rsp_if rsp_bus ();

   bspline_to_bezier_points_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 10 ns period
   always #5 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d points pending",
                  cycle_count, board.due_points.size());
         $display("simulation failed");
         $finish;
      end
   end

   // result side: check each accepted beat, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_point(rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z, rsp_bus.run_last);
      if (stall)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // long receiver hold-off in its own process, so the block backs up into req_bus
   task automatic hold_receiver(int cycles);
      stall <= 1'b1;
      repeat (cycles) @(posedge clock);
      stall <= 1'b0;
   endtask

   // offer one de boor point, with random idle cycles before it
   task automatic send_point(coord_type x, coord_type y, coord_type z, logic new_curve);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.in_x      <= x;
      req_bus.in_y      <= y;
      req_bus.in_z      <= z;
      req_bus.new_curve <= new_curve;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      // accepted at this edge
      board.note_point(x, y, z, new_curve);
      points_sent++;
      if (new_curve)
         curves_started++;
   endtask

   // full-range values, with extremes and small ones where rounding shows
   function automatic coord_type pick_coord();
      case ($urandom_range(9))
         0: return C_MAX;
         1: return C_MIN;
         2: return '0;
         3: return '1;
         4, 5: return coord_type'($signed($urandom_range(2000)) - 1000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // well-formed curves of random length, plus short and broken ones
   task automatic random_phase(int points);
      int   count;
      int   len;
      int   i;
      logic opens;
      count = 0;
      while (count < points) begin
         case ($urandom_range(19))
            0, 1, 2: len = $urandom_range(1, 3);
            3, 4, 5: len = $urandom_range(8, 14);
            default: len = $urandom_range(4, 7);
         endcase
         // now and then carry on the previous curve instead of opening one
         opens = ($urandom_range(9) != 0);
         for (i = 0; i < len; i++) begin
            send_point(pick_coord(), pick_coord(), pick_coord(),
                       (i == 0) ? opens : ($urandom_range(49) == 0));
            count++;
            // receiver stops dead while points keep coming
            if (send_idle_pct == 0 && count == 10 && !stall)
               fork
                  hold_receiver(HOLD_CYCLES);
               join_none
         end
      end
   endtask

   initial begin
      board = new;
      reset <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.in_x      <= '0;
      req_bus.in_y      <= '0;
      req_bus.in_z      <= '0;
      req_bus.new_curve <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // straight out of reset without new_curve: the count starts at zero anyway
      send_point(1, 2, 3, 1'b0);
      send_point(-1, -2, -3, 1'b0);
      send_point(5, -7, 11, 1'b0);
      send_point(100, -100, 0, 1'b0);

      // long curve of extremes, the count saturates
      send_point(C_MAX, C_MIN, '0, 1'b1);
      send_point(C_MAX, C_MIN, '1, 1'b0);
      send_point(C_MAX, C_MIN, 1, 1'b0);
      send_point(C_MAX, C_MIN, C_MAX, 1'b0);
      send_point(C_MIN, C_MAX, C_MIN, 1'b0);
      send_point('0, '1, C_MAX, 1'b0);
      send_point('1, '0, C_MIN, 1'b0);
      send_point(C_MAX, C_MAX, C_MAX, 1'b0);
      send_point(C_MIN, C_MIN, C_MIN, 1'b0);
      send_point(-5, 7, -13, 1'b0);

      // one-point curves back to back, old window must not leak
      send_point(3, 3, 3, 1'b1);
      send_point(C_MIN, C_MAX, '1, 1'b1);

      // small negatives where floor and truncation differ
      send_point(-7, -11, -13, 1'b1);
      send_point(2, -3, 5, 1'b0);
      send_point(C_MIN, '1, 1, 1'b0);
      send_point(-2, -4, -8, 1'b0);
      send_point(9, -9, 1, 1'b0);

      // slow receiver
      random_phase(PHASE_POINTS);

      // slow sender
      send_idle_pct = 72;
      recv_idle_pct = 15;
      random_phase(PHASE_POINTS);

      // full rate, with the long hold-off in the middle
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(PHASE_POINTS);

      req_bus.valid <= 1'b0;
      while (board.due_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d de boor points over %0d new curves, %0d bezier points checked",
               points_sent, curves_started, board.checked);
      $display("idle mixes on both sides, a %0d-cycle receiver hold-off, %0d mismatches",
               HOLD_CYCLES, board.errors);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
